// File: hw/rtl/length_prefixed_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_defines
// Assertion macros shared by the deframer checker
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

// File: hw/rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants of the length-prefixed frame deframer
// ----------------------------------------------------------------------------
package lpfd_pkg;

   localparam int unsigned MAX_FRAME_W = 13;
   localparam int unsigned LENGTH_W    = 16;

   localparam logic [MAX_FRAME_W-1:0] MAX_FRAME_RESET = 13'd1200;
   localparam logic [LENGTH_W:0]      HEADER_BYTES    = 17'd3;

   // result status codes
   localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
   localparam logic [1:0] STATUS_ABORTED = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       abort;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] proto;
      logic       first_byte;
      logic       last_byte;
      logic [1:0] status;
   } rsp_type;

   // result of one item as handed from the parser to the output buffer
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   // header hunt / payload state
   typedef enum logic [3:0] {
      ST_LEN_HI  = 4'b0001,
      ST_LEN_LO  = 4'b0010,
      ST_PROTO   = 4'b0100,
      ST_PAYLOAD = 4'b1000
   } state_type;

endpackage

// File: hw/rtl/lpfd_parser.sv
// ----------------------------------------------------------------------------
// lpfd_parser
// Header hunt and payload tracking, one stream byte per accepted item
// ----------------------------------------------------------------------------
module lpfd_parser
   import lpfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_accept,
   input  req_type                item,
   input  logic [MAX_FRAME_W-1:0] max_frame_bytes,
   output res_type                result
);

   state_type             state_ff, state_in;
   logic [LENGTH_W-1:0]   frame_length_ff, frame_length_in;
   logic [7:0]            protocol_id_ff, protocol_id_in;
   logic [LENGTH_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [LENGTH_W:0]     length_sum;
   logic                  too_long;
   logic                  first_mark;
   logic                  last_mark;

   // header size check and payload marks
   assign length_sum = {1'b0, frame_length_ff} + HEADER_BYTES;
   assign too_long   = length_sum > {{(LENGTH_W + 1 - MAX_FRAME_W){1'b0}}, max_frame_bytes};
   assign first_mark = (bytes_left_ff == frame_length_ff);
   assign last_mark  = (bytes_left_ff <= 16'd1);

   // next state and result of the item
   always_comb begin
      state_in        = state_ff;
      frame_length_in = frame_length_ff;
      protocol_id_in  = protocol_id_ff;
      bytes_left_in   = bytes_left_ff;
      result          = '0;
      if (item.abort) begin
         // drop any partial frame, report unless idle
         if (state_ff == ST_PAYLOAD) begin
            result.valid       = 1'b1;
            result.data.proto  = protocol_id_ff;
            result.data.status = STATUS_ABORTED;
         end else if (state_ff != ST_LEN_HI) begin
            result.valid       = 1'b1;
            result.data.status = STATUS_ABORTED;
         end
         state_in      = ST_LEN_HI;
         bytes_left_in = '0;
      end else begin
         unique case (state_ff)
            ST_LEN_HI: begin
               frame_length_in = {item.rx_byte, 8'h00};
               state_in        = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               frame_length_in = {frame_length_ff[15:8], item.rx_byte};
               state_in        = ST_PROTO;
            end
            ST_PROTO: begin
               protocol_id_in = item.rx_byte;
               // size check wins over the zero-length drop
               priority if (too_long) begin
                  result.valid       = 1'b1;
                  result.data.proto  = item.rx_byte;
                  result.data.status = STATUS_LEN_ERR;
                  state_in           = ST_LEN_HI;
                  bytes_left_in      = '0;
               end else if (frame_length_ff == '0) begin
                  state_in      = ST_LEN_HI;
                  bytes_left_in = '0;
               end else begin
                  state_in      = ST_PAYLOAD;
                  bytes_left_in = frame_length_ff;
               end
            end
            ST_PAYLOAD: begin
               result.valid           = 1'b1;
               result.data.out_byte   = item.rx_byte;
               result.data.proto      = protocol_id_ff;
               result.data.first_byte = first_mark;
               result.data.last_byte  = last_mark;
               result.data.status     = STATUS_PAYLOAD;
               bytes_left_in          = bytes_left_ff - 16'd1;
               if (last_mark) begin
                  state_in      = ST_LEN_HI;
                  bytes_left_in = '0;
               end
            end
            default: begin
               state_in = ST_LEN_HI;
            end
         endcase
      end
      // nothing moves without an accepted item
      if (!item_accept) begin
         state_in        = state_ff;
         frame_length_in = frame_length_ff;
         protocol_id_in  = protocol_id_ff;
         bytes_left_in   = bytes_left_ff;
         result.valid    = 1'b0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LEN_HI;
         frame_length_ff <= '0;
         protocol_id_ff  <= '0;
         bytes_left_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         frame_length_ff <= frame_length_in;
         protocol_id_ff  <= protocol_id_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

endmodule

// File: hw/rtl/lpfd_outbuf.sv
// ----------------------------------------------------------------------------
// lpfd_outbuf
// Result register with a skid entry, keeps the input side moving under stall
// ----------------------------------------------------------------------------
module lpfd_outbuf
   import lpfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  res_type result,
   output logic    full,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign take      = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // refill the output register from the skid entry first, then new results
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !take) begin
         if (result.valid) begin
            skid_data_in  = result.data;
            skid_valid_in = 1'b1;
         end
      end else begin
         out_valid_in = result.valid;
         out_data_in  = result.data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: hw/rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream of length-prefixed frames into tagged payload bytes
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while req_stall is low. A frame is a 16-bit
// big-endian payload length, a protocol byte and the payload; each payload
// byte comes out with the protocol byte and first/last marks. A frame whose
// length plus three header bytes exceeds max_frame_bytes yields one
// length-error item, and an abort in the middle of a frame yields one aborted
// item. Zero-length frames that pass the size check leave no trace. The parser
// updates its state in the cycle a byte is accepted; the result is registered
// for rsp_, and the sustained rate is one byte per cycle without rsp_stall.
// A two-entry output buffer (result register plus skid entry) absorbs
// rsp_stall; req_stall rises only once both entries are full. max_frame_bytes
// resets to 1200 and is written through csr_, which is always ready.
module length_prefixed_frame_deframer
   import lpfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [MAX_FRAME_W-1:0] csr_wdata
);

   logic [MAX_FRAME_W-1:0] max_frame_ff;
   logic                   req_accept;
   res_type                result;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;

   // size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
      end else if (csr_valid && csr_ready) begin
         max_frame_ff <= csr_wdata;
      end
   end

   lpfd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .item_accept     (req_accept),
      .item            (req_data),
      .max_frame_bytes (max_frame_ff),
      .result          (result)
   );

   lpfd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// File: hw/rtl/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_checker
   import lpfd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [MAX_FRAME_W-1:0] csr_wdata
);

   // a stalled result holds
   `LPFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // input back-pressure only while a result is waiting
   `LPFD_ASSERT_IMPL(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)

   // status items carry no byte and no marks
   `LPFD_ASSERT_IMPL(a_status_clean, clock, reset, rsp_valid && rsp_data.status != STATUS_PAYLOAD, rsp_data.out_byte == 8'h00 && !rsp_data.first_byte && !rsp_data.last_byte)

   // only defined status codes appear
   `LPFD_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_data.status == STATUS_PAYLOAD || rsp_data.status == STATUS_LEN_ERR || rsp_data.status == STATUS_ABORTED)

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

// File: tb/deframe_check_pkg.sv
// ----------------------------------------------------------------------------
// deframe_check_pkg
// Scoreboard for the length-prefixed frame deframer
// ----------------------------------------------------------------------------
// Follows the header hunt and payload count of the deframer byte by byte.
// Each accepted stream item is turned into its expected output item, if it
// has one. Each output item is then compared field by field with the oldest
// expected item.
package deframe_check_pkg;

   import lpfd_pkg::*;

   class deframe_scoreboard;

      // own copy of the register and of the parser state
      logic [MAX_FRAME_W-1:0] max_frame;
      logic [1:0]             hdr_count;
      bit                     in_payload;
      logic [15:0]            frame_len;
      logic [15:0]            bytes_left;
      logic [7:0]             proto_id;

      rsp_type     expected_out_q[$];
      int unsigned errors;
      int unsigned payload_cnt;
      int unsigned len_err_cnt;
      int unsigned abort_cnt;

      function new();
         max_frame   = MAX_FRAME_RESET;
         hdr_count   = '0;
         in_payload  = 1'b0;
         frame_len   = '0;
         bytes_left  = '0;
         proto_id    = '0;
         errors      = 0;
         payload_cnt = 0;
         len_err_cnt = 0;
         abort_cnt   = 0;
      endfunction

      function void set_max_frame(logic [MAX_FRAME_W-1:0] value);
         max_frame = value;
      endfunction

      function int unsigned pending();
         return expected_out_q.size();
      endfunction

      function void back_to_hunt();
         hdr_count  = '0;
         in_payload = 1'b0;
         bytes_left = '0;
      endfunction

      // works out the output item caused by one accepted stream item
      function void deframe_item(req_type item);
         rsp_type exp_out;
         bit      produces;
         exp_out  = '0;
         produces = 1'b0;
         if (item.abort) begin
            // a partial frame is dropped and reported, an idle link is not
            if (in_payload || hdr_count != 0) begin
               exp_out.proto  = in_payload ? proto_id : 8'h00;
               exp_out.status = STATUS_ABORTED;
               produces       = 1'b1;
               back_to_hunt();
            end
         end else if (in_payload) begin
            exp_out.out_byte   = item.rx_byte;
            exp_out.proto      = proto_id;
            exp_out.first_byte = (bytes_left == frame_len);
            exp_out.last_byte  = (bytes_left <= 16'd1);
            exp_out.status     = STATUS_PAYLOAD;
            produces           = 1'b1;
            bytes_left         = bytes_left - 16'd1;
            if (exp_out.last_byte) begin
               back_to_hunt();
            end
         end else begin
            case (hdr_count)
               2'd0: begin
                  frame_len = {item.rx_byte, 8'h00};
                  hdr_count = 2'd1;
               end
               2'd1: begin
                  frame_len[7:0] = item.rx_byte;
                  hdr_count      = 2'd2;
               end
               default: begin
                  proto_id  = item.rx_byte;
                  hdr_count = 2'd0;
                  // size check comes before the zero-length drop
                  if (int'(frame_len) + 3 > int'(max_frame)) begin
                     exp_out.proto  = proto_id;
                     exp_out.status = STATUS_LEN_ERR;
                     produces       = 1'b1;
                     back_to_hunt();
                  end else if (frame_len == 16'd0) begin
                     back_to_hunt();
                  end else begin
                     in_payload = 1'b1;
                     bytes_left = frame_len;
                  end
               end
            endcase
         end
         if (produces) begin
            expected_out_q.push_back(exp_out);
         end
      endfunction

      function string describe(rsp_type r);
         return $sformatf("byte=%h proto=%h first=%b last=%b status=%0d",
                          r.out_byte, r.proto, r.first_byte, r.last_byte, r.status);
      endfunction

      function void flag_error(string msg);
         if (errors < 10) begin
            $display("[%0t] ERROR %s", $time, msg);
         end
         errors++;
      endfunction

      // compares one accepted output item with the oldest expectation
      function void check_output(rsp_type got);
         rsp_type exp_out;
         if (expected_out_q.size() == 0) begin
            flag_error({"unexpected output item: ", describe(got)});
            return;
         end
         exp_out = expected_out_q.pop_front();
         if (got.out_byte !== exp_out.out_byte || got.proto !== exp_out.proto ||
             got.first_byte !== exp_out.first_byte ||
             got.last_byte !== exp_out.last_byte || got.status !== exp_out.status) begin
            flag_error({"expected ", describe(exp_out), " got ", describe(got)});
         end
         case (exp_out.status)
            STATUS_PAYLOAD: payload_cnt++;
            STATUS_LEN_ERR: len_err_cnt++;
            default:        abort_cnt++;
         endcase
      endfunction

   endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the length-prefixed frame deframer
// ----------------------------------------------------------------------------
// Feeds byte streams of frames through the deframer: a directed opening with
// boundary bytes, zero-length frames, length errors and aborts at every stage,
// then random frames under several max_frame_bytes settings, from below the
// smallest usable size to the full register range. Both channels idle in
// random bursts, the output side once holds off long enough to back up the
// input, and every output item is checked against a scoreboard.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import lpfd_pkg::*;
   import deframe_check_pkg::*;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [MAX_FRAME_W-1:0] csr_wdata = '0;

   deframe_scoreboard sb;

   int unsigned cfg_max       = MAX_FRAME_RESET;
   int unsigned items_sent    = 0;
   int unsigned settings_used = 0;
   bit          idling        = 1'b1;
   bit          long_hold_req = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned burst_left    = 0;

   length_prefixed_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // output side: check accepted items, stall in bursts or for a long hold
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_output(rsp_data);
         end
         if (long_hold_req) begin
            hold_left     = 300;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (burst_left > 0) begin
            burst_left--;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 4);
         end
         rsp_stall <= (hold_left > 0) || (burst_left > 0);
      end
   end

   // offer one stream item and wait until it is taken
   task automatic send_item(logic [7:0] value, logic abort_link);
      req_type item;
      item.rx_byte = value;
      item.abort   = abort_link;
      if (idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.deframe_item(item);
      items_sent++;
   endtask

   // header, then payload if the frame passes; abort replaces item abort_at
   task automatic send_frame(int unsigned len, logic [7:0] proto, int abort_at);
      int unsigned total;
      int unsigned pos;
      logic [7:0]  value;
      total = (len + 3 > cfg_max || len == 0) ? 3 : len + 3;
      for (pos = 0; pos < total; pos++) begin
         if (abort_at == int'(pos)) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
            return;
         end
         case (pos)
            0:       value = len[15:8];
            1:       value = len[7:0];
            2:       value = proto;
            default: value = 8'($urandom_range(0, 255));
         endcase
         send_item(value, 1'b0);
      end
   endtask

   // mostly good frames, some oversized, empty or cut off, some idle aborts
   task automatic random_frame();
      int unsigned pick;
      int unsigned len;
      int unsigned cap;
      int          abort_at;
      pick     = $urandom_range(0, 99);
      abort_at = -1;
      if (pick < 5) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      if (pick < 13) begin
         len = $urandom_range((cfg_max > 2) ? cfg_max - 2 : 0, 65535);
      end else if (pick < 17) begin
         len = 0;
      end else if (cfg_max < 4) begin
         len = $urandom_range(1, 8);
      end else begin
         cap = (cfg_max - 3 > 48) ? 48 : cfg_max - 3;
         len = $urandom_range(1, cap);
         if (pick >= 93) begin
            abort_at = $urandom_range(1, len + 2);
         end
      end
      send_frame(len, 8'($urandom_range(0, 255)), abort_at);
   endtask

   // release the input and wait for every expected item, plus pipeline slack
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_frame(logic [MAX_FRAME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_max_frame(value);
      cfg_max = value;
      settings_used++;
   endtask

   // one register setting: boundary frames first, then random frames
   task automatic run_setting(logic [MAX_FRAME_W-1:0] value, int unsigned n_items);
      int unsigned start;
      wait_drained();
      write_max_frame(value);
      if (cfg_max >= 4 && cfg_max - 3 <= 64) begin
         send_frame(cfg_max - 3, 8'($urandom_range(0, 255)), -1);
      end
      send_frame((cfg_max >= 2) ? cfg_max - 2 : 0, 8'($urandom_range(0, 255)), -1);
      start = items_sent;
      while (items_sent - start < n_items) random_frame();
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening under the reset setting
      send_frame(1, 8'hFF, -1);
      send_frame(2, 8'h00, -1);
      send_frame(0, 8'h5A, -1);
      send_frame(16'hFFFF, 8'hA5, -1);
      send_item(8'hFF, 1'b1);
      send_frame(3, 8'h11, 1);
      send_frame(5, 8'h22, 2);
      send_frame(3, 8'h77, 5);

      run_setting(13'd4, 150);
      run_setting(13'd0, 80);
      run_setting(13'd64, 200);

      // register value 4096: a long frame under a long hold,
      // then a frame one byte too long
      wait_drained();
      write_max_frame(13'd4096);
      long_hold_req = 1'b1;
      send_frame(300, 8'h3C, -1);
      send_frame(4094, 8'hC3, -1);
      run_setting(13'd4096, 150);

      run_setting(13'h1FFF, 150);
      run_setting(13'($urandom_range(4, 200)), 150);

      // closing stretch with no idling on either side
      wait_drained();
      idling = 1'b0;
      run_setting(MAX_FRAME_RESET, 200);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d stream items under %0d max_frame_bytes settings",
               items_sent, settings_used);
      $display("checked %0d payload bytes, %0d length errors, %0d aborted frames",
               sb.payload_cnt, sb.len_err_cnt, sb.abort_cnt);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d items still expected", sb.errors, sb.pending());
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("timeout with %0d items still expected", sb.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lpfd_pkg.sv
hw/rtl/lpfd_parser.sv
hw/rtl/lpfd_outbuf.sv
hw/rtl/length_prefixed_frame_deframer.sv
hw/rtl/lpfd_checker.sv
tb/deframe_check_pkg.sv
tb/tb_top.sv
